// ===== sv/float_to_decimal_text_macros.svh =====
// ----------------------------------------------------------------------------
// float_to_decimal_text assertion macros
// Shorthand for the clocked checks of the float to text block. Each macro
// expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_DECIMAL_TEXT_MACROS_SVH
`define FLOAT_TO_DECIMAL_TEXT_MACROS_SVH

// Check that a condition implies a consequence on the same edge
`define FTDT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never occurs outside reset
`define FTDT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/ftdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ftdt_pkg
// Shared types and constants of the float to decimal text block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftdt_pkg;

  // Input word and field layout
  localparam int FLOAT_W = 32;
  localparam int MANT_W  = 23;
  localparam int EXP_W   = 8;

  // Integer part is below 2**19, so six decimal digits hold it
  localparam int IPART_W = 19;
  localparam int NDIG    = 6;
  localparam int BCD_W   = 4 * NDIG;
  localparam int FRAC_W  = 3;
  localparam int NCELL   = IPART_W;

  // Text
  localparam int TEXT_MAX = 7;
  localparam int LEN_W    = 3;

  // Exponent handling
  localparam logic [EXP_W-1:0]        EXP_BIAS   = 8'd127;
  localparam logic signed [EXP_W-1:0] EXP_HI     = 8'sd18;
  localparam logic signed [EXP_W-1:0] EXP_LO     = -8'sd3;
  localparam logic [EXP_W-1:0]        SHIFT_BASE = 8'd20;

  // Kind of text to produce
  typedef enum logic [2:0] {
    KIND_NUM  = 3'b001,
    KIND_INF  = 3'b010,
    KIND_ZERO = 3'b100
  } kind_t;

  typedef logic [NDIG-1:0][3:0] digits_t;

  // Fields that ride along the cell chain untouched
  typedef struct packed {
    kind_t             kind;
    logic              neg;
    logic [FRAC_W-1:0] frac;
  } side_t;

  // Word held in each cell
  typedef struct packed {
    digits_t            bcd;
    logic [IPART_W-1:0] bin;
    side_t              side;
  } cell_data_t;

endpackage

// ===== sv/ftdt_front.sv =====
// ----------------------------------------------------------------------------
// ftdt_front
// Input stage: classify the exponent, align the significand and split it
// into integer part and three fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftdt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic [ftdt_pkg::FLOAT_W-1:0] in_bits,
  output logic                         out_vld,
  input  logic                         out_rdy,
  output ftdt_pkg::cell_data_t         out_data
);
  import ftdt_pkg::*;

  logic                     vld_r;
  cell_data_t               data_r;
  cell_data_t               data_nxt;
  logic [EXP_W-1:0]         ewrap;
  logic [MANT_W:0]          sig;
  logic [EXP_W-1:0]         shamt;
  logic [MANT_W:0]          aligned;

  // Decode exponent and align significand
  always_comb begin
    ewrap   = in_bits[FLOAT_W-2 -: EXP_W] - EXP_BIAS;
    sig     = {1'b1, in_bits[MANT_W-1:0]};
    shamt   = SHIFT_BASE - ewrap;
    aligned = sig >> shamt[4:0];

    data_nxt.bcd       = '0;
    data_nxt.bin       = aligned[IPART_W+FRAC_W-1:FRAC_W];
    data_nxt.side.neg  = in_bits[FLOAT_W-1];
    data_nxt.side.frac = aligned[FRAC_W-1:0];
    if ($signed(ewrap) > EXP_HI) begin
      data_nxt.side.kind = KIND_INF;
    end else if ($signed(ewrap) < EXP_LO) begin
      data_nxt.side.kind = KIND_ZERO;
    end else begin
      data_nxt.side.kind = KIND_NUM;
    end
  end

  assign in_rdy = !vld_r || out_rdy;

  // Hold until the next cell takes the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sv/ftdt_cell.sv =====
// ----------------------------------------------------------------------------
// ftdt_cell
// One shift-and-add-three step of the binary to decimal chain: adjust each
// decimal digit, then shift in the next integer bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftdt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  output logic                 in_rdy,
  input  ftdt_pkg::cell_data_t in_data,
  output logic                 out_vld,
  input  logic                 out_rdy,
  output ftdt_pkg::cell_data_t out_data
);
  import ftdt_pkg::*;

  logic             vld_r;
  cell_data_t       data_r;
  cell_data_t       data_nxt;
  digits_t          adj;
  logic [BCD_W-1:0] adj_flat;

  // Add three to every digit of five or more, then shift left one bit
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (in_data.bcd[i] >= 4'd5) ? in_data.bcd[i] + 4'd3 : in_data.bcd[i];
    end
    adj_flat      = adj;
    data_nxt      = in_data;
    data_nxt.bcd  = {adj_flat[BCD_W-2:0], in_data.bin[IPART_W-1]};
    data_nxt.bin  = {in_data.bin[IPART_W-2:0], 1'b0};
  end

  assign in_rdy = !vld_r || out_rdy;

  // Advance when the neighbor is free, otherwise hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// ===== sv/ftdt_format.sv =====
// ----------------------------------------------------------------------------
// ftdt_format
// Output register: lay out sign, integer digits, point and fraction (or Inf, or
// a single 0) as ASCII characters and compute the text length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftdt_format (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  output logic                        in_rdy,
  input  ftdt_pkg::cell_data_t        in_data,
  output logic                        out_vld,
  input  logic                        out_stall,
  output logic [ftdt_pkg::TEXT_MAX-1:0][7:0] out_text,
  output logic [ftdt_pkg::LEN_W-1:0]  out_len
);
  import ftdt_pkg::*;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_POINT = ".";
  localparam logic [7:0] CH_I     = "I";
  localparam logic [7:0] CH_N     = "n";
  localparam logic [7:0] CH_F     = "f";

  // Digit k of the decimal text of frac/8, three digits
  function automatic logic [7:0] eighth_char(input logic [FRAC_W-1:0] frac,
                                             input logic [1:0] k);
    logic [11:0] dig;
    begin
      case (frac)
        3'd0:    dig = 12'h000;
        3'd1:    dig = 12'h125;
        3'd2:    dig = 12'h250;
        3'd3:    dig = 12'h375;
        3'd4:    dig = 12'h500;
        3'd5:    dig = 12'h625;
        3'd6:    dig = 12'h750;
        default: dig = 12'h875;
      endcase
      case (k)
        2'd0:    eighth_char = CH_ZERO + {4'd0, dig[11:8]};
        2'd1:    eighth_char = CH_ZERO + {4'd0, dig[7:4]};
        default: eighth_char = CH_ZERO + {4'd0, dig[3:0]};
      endcase
    end
  endfunction

  logic                          vld_r;
  logic [TEXT_MAX-1:0][7:0]      text_r;
  logic [LEN_W-1:0]              len_r;
  logic [TEXT_MAX-1:0][7:0]      text_nxt;
  logic [LEN_W-1:0]              len_nxt;
  logic [2:0]                    nd;
  logic [2:0]                    pos;
  logic [2:0]                    len_int;
  logic                          point;
  logic [3:0]                    len_frac;
  logic [2:0]                    q;
  logic [2:0]                    di;
  logic [3:0]                    digit;

  // Count significant digits, at least one
  always_comb begin
    nd = 3'd1;
    for (int i = 1; i < NDIG; i++) begin
      if (in_data.bcd[i] != 4'd0) begin
        nd = 3'(i + 1);
      end
    end
    pos      = {2'b00, in_data.side.neg};
    len_int  = pos + nd;
    point    = (len_int <= 3'd5);
    len_frac = {1'b0, len_int} + 4'd4;
  end

  // Build the characters position by position
  always_comb begin
    text_nxt = '0;
    len_nxt  = 3'd1;
    q        = '0;
    di       = '0;
    digit    = '0;
    unique case (in_data.side.kind)
      KIND_INF: begin
        text_nxt[0] = CH_I;
        text_nxt[1] = CH_N;
        text_nxt[2] = CH_F;
        len_nxt     = 3'd3;
      end
      KIND_ZERO: begin
        text_nxt[0] = CH_ZERO;
        len_nxt     = 3'd1;
      end
      KIND_NUM: begin
        for (int p = 0; p < TEXT_MAX; p++) begin
          q     = 3'(p) - pos;
          di    = nd - 3'd1 - q;
          digit = in_data.bcd[di];
          if (3'(p) < pos) begin
            text_nxt[p] = CH_MINUS;
          end else if (q < nd) begin
            text_nxt[p] = CH_ZERO + {4'd0, digit};
          end else if (point && q == nd) begin
            text_nxt[p] = CH_POINT;
          end else if (point && ({1'b0, q} <= {1'b0, nd} + 4'd3)) begin
            text_nxt[p] = eighth_char(in_data.side.frac, 2'(q - nd - 3'd1));
          end else begin
            text_nxt[p] = CH_NUL;
          end
        end
        if (!point) begin
          len_nxt = len_int;
        end else if (len_frac > 4'(TEXT_MAX)) begin
          len_nxt = 3'(TEXT_MAX);
        end else begin
          len_nxt = len_frac[LEN_W-1:0];
        end
      end
      default: begin
        text_nxt[0] = CH_ZERO;
        len_nxt     = 3'd1;
      end
    endcase
  end

  assign in_rdy = !vld_r || !out_stall;

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      text_r <= text_nxt;
      len_r  <= len_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_text = text_r;
  assign out_len  = len_r;

endmodule

// ===== sv/float_to_decimal_text.sv =====
// ----------------------------------------------------------------------------
// float_to_decimal_text: IEEE single to short ASCII text, 1/8 resolution
// Stages from input accept to out_valid: input stage, 19 cells, output register.
// Throughput one word per cycle; each stage advances when its neighbor is free.
// Reset clears all stage valid bits at once; no clearing pass, ready right after.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_to_decimal_text_macros.svh"

module float_to_decimal_text (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ftdt_pkg::FLOAT_W-1:0] in_float_bits,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_char_0,
  output logic [7:0]                   out_char_1,
  output logic [7:0]                   out_char_2,
  output logic [7:0]                   out_char_3,
  output logic [7:0]                   out_char_4,
  output logic [7:0]                   out_char_5,
  output logic [7:0]                   out_char_6,
  output logic [ftdt_pkg::LEN_W-1:0]   out_text_length
);
  import ftdt_pkg::*;

  logic                     front_rdy;
  logic                     link_vld [0:NCELL];
  logic                     link_rdy [0:NCELL];
  cell_data_t               link_data [0:NCELL];
  logic [TEXT_MAX-1:0][7:0] text;

  // Classify and align the input word
  ftdt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_rdy   (front_rdy),
    .in_bits  (in_float_bits),
    .out_vld  (link_vld[0]),
    .out_rdy  (link_rdy[0]),
    .out_data (link_data[0])
  );

  assign in_stall = !front_rdy;

  // Binary to decimal chain, one integer bit per cell
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ftdt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (link_vld[g]),
      .in_rdy   (link_rdy[g]),
      .in_data  (link_data[g]),
      .out_vld  (link_vld[g+1]),
      .out_rdy  (link_rdy[g+1]),
      .out_data (link_data[g+1])
    );
  end

  // Lay out the text into the output register
  ftdt_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (link_vld[NCELL]),
    .in_rdy    (link_rdy[NCELL]),
    .in_data   (link_data[NCELL]),
    .out_vld   (out_valid),
    .out_stall (out_stall),
    .out_text  (text),
    .out_len   (out_text_length)
  );

  assign out_char_0 = text[0];
  assign out_char_1 = text[1];
  assign out_char_2 = text[2];
  assign out_char_3 = text[3];
  assign out_char_4 = text[4];
  assign out_char_5 = text[5];
  assign out_char_6 = text[6];

  // Checks on the formatted result
  `FTDT_ASSERT_NEVER(a_len_nonzero, out_valid && out_text_length == 3'd0, "zero text length")
  `FTDT_ASSERT_IMP(a_tail_zero, out_valid && out_text_length != 3'd7, out_char_6 == 8'h00, "char beyond length not zero")
  `FTDT_ASSERT_IMP(a_inf_len, out_valid && out_char_0 == "I", out_text_length == 3'd3 && out_char_3 == 8'h00, "bad Inf text")
  `FTDT_ASSERT_IMP(a_single_zero, out_valid && out_text_length == 3'd1, out_char_0 == "0" && out_char_1 == 8'h00, "one-char text not zero")

endmodule
